>>> sv/spr_pkg.sv
// ---------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the stream pattern replace block.
// ---------------------------------------------------------------------------
package spr_pkg;

  // stream unit and pattern storage
  localparam int UNIT_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W         = 5;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_MODE      = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_FIND_LOW       = 3'd2,
    REG_FIND_HIGH      = 3'd3,
    REG_REPLACE_LOW    = 3'd4,
    REG_REPLACE_HIGH   = 3'd5
  } cfg_reg_t;

  // current configuration
  typedef struct packed {
    logic                     unit_mode;
    logic [LEN_W-1:0]         pattern_length;
    logic [2*CFG_DATA_W-1:0]  find_bytes;
    logic [2*CFG_DATA_W-1:0]  replace_bytes;
  } cfg_t;

  // load control from the scan stage into the result buffer
  typedef struct packed {
    logic load;
    logic stream_end;
  } load_t;

endpackage

>>> sv/stream_pattern_replace.sv
// ---------------------------------------------------------------------------
// stream_pattern_replace
// Streaming fixed-pattern find and replace over 8-bit or 16-bit units.
// ---------------------------------------------------------------------------
// Each input unit is registered, then scanned combinationally against the
// held window; the results it causes (none up to MAX_PATTERN, capped at
// 16) load into a result buffer that sends one unit per beat on the out_
// side. An input that causes no result passes the scan even while the
// buffer drains; an input that causes r results occupies the result buffer
// for r beats, and the next result-bearing input loads on the beat that
// takes the last of them, so while out_tready stays high the block
// sustains one unit in and one unit out per cycle. The window needs no
// clearing after reset. Configuration writes are taken at any time but
// must only be made while the block is idle.
// ---------------------------------------------------------------------------
module stream_pattern_replace import spr_pkg::*; #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [UNIT_W-1:0]     in_tdata,   // [15:0] unit_in
  input  logic                  in_tlast,   // stream_last
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [UNIT_W-1:0]     out_tdata,  // [15:0] unit_out
  output logic                  out_tuser,  // [0] run_end
  output logic                  out_tlast   // stream_end
);

  localparam int DEPTH = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                         cfg;
  logic                         in_vld_r;
  logic [UNIT_W-1:0]            in_unit_r;
  logic                         in_last_r;
  logic [DEPTH-1:0][UNIT_W-1:0] res_units;
  logic [CNT_W-1:0]             res_cnt;
  logic                         buf_free;
  logic                         advance;
  load_t                        ld;

  // configuration registers
  spr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // scan advances when its results have somewhere to go
  assign advance       = in_vld_r && (buf_free || (res_cnt == '0));
  assign in_tready     = !in_vld_r || advance;
  assign ld.load       = advance && (res_cnt != '0);
  assign ld.stream_end = in_last_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_unit_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // window and scan
  spr_core #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (advance),
    .unit_in   (in_unit_r),
    .last_in   (in_last_r),
    .res_units (res_units),
    .res_cnt   (res_cnt)
  );

  // result buffer
  spr_out_buf #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .res_units  (res_units),
    .res_cnt    (res_cnt),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/spr_cfg_regs.sv
// ---------------------------------------------------------------------------
// spr_cfg_regs
// Configuration register file: unit mode, pattern length, find and
// replacement patterns.
// ---------------------------------------------------------------------------
module spr_cfg_regs import spr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_mode      <= 1'b0;
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.find_bytes     <= '0;
      cfg_r.replace_bytes  <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_UNIT_MODE:      cfg_r.unit_mode <= cfg_data[0];
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[LEN_W-1:0];
        REG_FIND_LOW:       cfg_r.find_bytes[CFG_DATA_W-1:0] <= cfg_data;
        REG_FIND_HIGH:      cfg_r.find_bytes[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        REG_REPLACE_LOW:    cfg_r.replace_bytes[CFG_DATA_W-1:0] <= cfg_data;
        REG_REPLACE_HIGH:   cfg_r.replace_bytes[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/spr_core.sv
// ---------------------------------------------------------------------------
// spr_core
// Held-back window and combinational scan: appends one unit, finds the
// smallest head drop that leaves a pattern prefix, and builds the result list.
// ---------------------------------------------------------------------------
module spr_core import spr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          advance,
  input  logic [UNIT_W-1:0]             unit_in,
  input  logic                          last_in,
  output logic [DEPTH-1:0][UNIT_W-1:0]  res_units,
  output logic [CNT_W-1:0]              res_cnt
);

  logic [UNIT_W-1:0] win_r    [DEPTH];
  logic [UNIT_W-1:0] win_nxt  [DEPTH];
  logic [CNT_W-1:0]  win_cnt_r;
  logic [CNT_W-1:0]  win_cnt_nxt;

  logic [UNIT_W-1:0] cur      [DEPTH];
  logic [UNIT_W-1:0] msk      [DEPTH];
  logic [UNIT_W-1:0] find_u   [DEPTH];
  logic [UNIT_W-1:0] rep_u    [DEPTH];
  logic [DEPTH:0]    ok;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  rem;
  logic              full;

  // effective pattern length, clamped to one and to the window depth
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = CNT_W'(1);
    end else if (int'(cfg.pattern_length) > DEPTH) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = CNT_W'(cfg.pattern_length);
    end
  end

  // window with the new unit appended, masked view and pattern units
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cur[i]    = (CNT_W'(i) == win_cnt_r) ? unit_in : win_r[i];
      msk[i]    = cfg.unit_mode ? cur[i] : {{(UNIT_W-BYTE_W){1'b0}}, cur[i][BYTE_W-1:0]};
      find_u[i] = {{(UNIT_W-BYTE_W){1'b0}}, cfg.find_bytes[i*BYTE_W +: BYTE_W]};
      rep_u[i]  = {{(UNIT_W-BYTE_W){1'b0}}, cfg.replace_bytes[i*BYTE_W +: BYTE_W]};
    end
  end

  assign n = win_cnt_r + CNT_W'(1);

  // every head drop checked in parallel against the find pattern
  always_comb begin
    for (int kk = 0; kk <= DEPTH; kk++) begin
      ok[kk] = (CNT_W'(kk) <= n) && ((n - CNT_W'(kk)) <= len);
      for (int i = kk; i < DEPTH; i++) begin
        if ((CNT_W'(i) < n) && (msk[i] != find_u[i-kk])) begin
          ok[kk] = 1'b0;
        end
      end
    end
  end

  // smallest passing drop; dropping everything always passes
  always_comb begin
    k = n;
    for (int kk = DEPTH; kk >= 0; kk--) begin
      if (ok[kk]) begin
        k = CNT_W'(kk);
      end
    end
  end

  assign rem     = n - k;
  assign full    = (rem == len);
  assign res_cnt = (full || last_in) ? n : k;

  // result list: dropped heads, then replacement or flushed tail
  always_comb begin
    logic [UNIT_W-1:0] rep_sh;
    for (int i = 0; i < DEPTH; i++) begin
      rep_sh = rep_u[0];
      for (int kk = 0; kk <= i; kk++) begin
        if (CNT_W'(kk) == k) begin
          rep_sh = rep_u[i-kk];
        end
      end
      res_units[i] = (full && (CNT_W'(i) >= k)) ? rep_sh : msk[i];
    end
  end

  // surviving window moves down to the front
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      win_nxt[i] = cur[i];
      for (int kk = 0; kk < DEPTH - i; kk++) begin
        if (CNT_W'(kk) == k) begin
          win_nxt[i] = cur[i+kk];
        end
      end
    end
    win_cnt_nxt = (full || last_in) ? '0 : rem;
  end

  // window count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
    end else if (advance) begin
      win_cnt_r <= win_cnt_nxt;
    end
  end

  // window units
  always_ff @(posedge clk) begin
    if (advance) begin
      win_r <= win_nxt;
    end
  end

endmodule

>>> sv/spr_out_buf.sv
// ---------------------------------------------------------------------------
// spr_out_buf
// Result buffer: holds the results of one input and sends them one per beat.
// ---------------------------------------------------------------------------
module spr_out_buf import spr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  load_t                         ld,
  input  logic [DEPTH-1:0][UNIT_W-1:0]  res_units,
  input  logic [CNT_W-1:0]              res_cnt,
  output logic                          free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [UNIT_W-1:0]             out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  logic [UNIT_W-1:0] units_r [DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  rd_r;
  logic              busy_r;
  logic              end_r;
  logic              at_last;
  logic              pop;

  assign at_last    = ((CNT_W'(rd_r) + CNT_W'(1)) == cnt_r);
  assign pop        = busy_r && out_tready;
  assign free       = !busy_r || (pop && at_last);

  assign out_tvalid = busy_r;
  assign out_tdata  = units_r[rd_r];
  assign out_tuser  = at_last;
  assign out_tlast  = at_last && end_r;

  // read pointer and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rd_r   <= '0;
    end else if (ld.load) begin
      busy_r <= 1'b1;
      rd_r   <= '0;
    end else if (pop) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        rd_r <= rd_r + IDX_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ld.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        units_r[i] <= res_units[i];
      end
      cnt_r <= res_cnt;
      end_r <= ld.stream_end;
    end
  end

endmodule
